// File: hdl/bc_pkg.sv
// Shared widths, status codes and controller/datapath interface types
// for the binomial coefficient block. No dependencies.
package bc_pkg;

  localparam int N_W    = 7;
  localparam int VAL_W  = 64;
  localparam int STAT_W = 2;
  localparam int PROD_W = VAL_W + N_W;
  localparam int CNT_W  = $clog2(PROD_W);
  localparam int N_MAX  = 127;

  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(PROD_W - 1);

  typedef enum logic [STAT_W-1:0] {
    STATUS_OK  = 2'd0,
    STATUS_OVF = 2'd1,
    STATUS_DOM = 2'd2
  } status_t;

  typedef struct packed {
    logic    load;
    logic    mul;
    logic    div;
    logic    update;
    logic    finish;
    status_t code;
  } bc_cmd_t;

  typedef struct packed {
    logic domain;
    logic steps_zero;
    logic quot_ovf;
  } bc_stat_t;

endpackage

// File: hdl/bc_datapath.sv
// Datapath: operand registers, 64x7 multiplier and bit-serial exact divider.
// Depends on bc_pkg.
module bc_datapath (
  input  logic                      clk,
  input  logic [bc_pkg::N_W-1:0]    n_items,
  input  logic [bc_pkg::N_W-1:0]    m_taken,
  input  bc_pkg::bc_cmd_t           cmd,
  output bc_pkg::bc_stat_t          stat,
  output logic [bc_pkg::VAL_W-1:0]  combinations,
  output logic [bc_pkg::STAT_W-1:0] status
);

  logic [bc_pkg::VAL_W-1:0]  running_value;
  logic [bc_pkg::N_W-1:0]    step_index;
  logic [bc_pkg::N_W-1:0]    falling_factor;
  logic [bc_pkg::N_W-1:0]    steps_left;
  logic                      domain;
  logic [bc_pkg::PROD_W-1:0] acc;
  logic [bc_pkg::N_W-1:0]    rem;

  logic                      dom_in;
  logic [bc_pkg::N_W-1:0]    m_eff;
  logic [bc_pkg::N_W:0]      r_shift;
  logic                      q_bit;
  logic [bc_pkg::N_W:0]      r_sub;
  logic [bc_pkg::VAL_W-1:0]  comb_next;

  assign dom_in = (m_taken > n_items) ||
                  ({1'b0, n_items} > (bc_pkg::N_W+1)'(bc_pkg::N_MAX));
  assign m_eff  = ({m_taken, 1'b0} > {1'b0, n_items}) ? (n_items - m_taken) : m_taken;

  assign r_shift = {rem, acc[bc_pkg::PROD_W-1]};
  assign q_bit   = (r_shift >= {1'b0, step_index});
  assign r_sub   = r_shift - {1'b0, step_index};

  assign stat.domain     = domain;
  assign stat.steps_zero = (steps_left == '0);
  assign stat.quot_ovf   = |acc[bc_pkg::PROD_W-1:bc_pkg::VAL_W];

  always_comb begin
    unique case (cmd.code)
      bc_pkg::STATUS_OK:  comb_next = running_value;
      bc_pkg::STATUS_OVF: comb_next = '1;
      default:            comb_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      domain         <= dom_in;
      running_value  <= bc_pkg::VAL_W'(1);
      falling_factor <= n_items;
      step_index     <= '0;
      steps_left     <= dom_in ? '0 : m_eff;
    end
    if (cmd.mul) begin
      step_index <= step_index + 1'b1;
      acc        <= bc_pkg::PROD_W'(running_value) * bc_pkg::PROD_W'(falling_factor);
      rem        <= '0;
    end
    if (cmd.div) begin
      rem <= q_bit ? r_sub[bc_pkg::N_W-1:0] : r_shift[bc_pkg::N_W-1:0];
      acc <= {acc[bc_pkg::PROD_W-2:0], q_bit};
    end
    if (cmd.update) begin
      running_value  <= acc[bc_pkg::VAL_W-1:0];
      falling_factor <= falling_factor - 1'b1;
      steps_left     <= steps_left - 1'b1;
    end
    if (cmd.finish) begin
      combinations <= comb_next;
      status       <= cmd.code;
    end
  end

endmodule

// File: hdl/bc_controller.sv
// Sequencer: load, per-step multiply, bit-serial divide, update, finish.
// Depends on bc_pkg.
module bc_controller (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  bc_pkg::bc_stat_t stat,
  output bc_pkg::bc_cmd_t  cmd,
  output logic             busy,
  output logic             done
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_UPD
  } state_t;

  state_t                  state;
  state_t                  state_next;
  logic [bc_pkg::CNT_W-1:0] bit_cnt;

  assign busy = (state != ST_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.code   = bc_pkg::STATUS_OK;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        priority if (stat.domain) begin
          cmd.finish = 1'b1;
          cmd.code   = bc_pkg::STATUS_DOM;
          state_next = ST_IDLE;
        end else if (stat.steps_zero) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end else begin
          cmd.mul    = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div = 1'b1;
        if (bit_cnt == bc_pkg::DIV_LAST) begin
          state_next = ST_UPD;
        end
      end
      ST_UPD: begin
        if (stat.quot_ovf) begin
          cmd.finish = 1'b1;
          cmd.code   = bc_pkg::STATUS_OVF;
          state_next = ST_IDLE;
        end else begin
          cmd.update = 1'b1;
          state_next = ST_CHECK;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      done    <= 1'b0;
      bit_cnt <= '0;
    end else begin
      state   <= state_next;
      done    <= cmd.finish;
      bit_cnt <= (state == ST_DIV) ? bit_cnt + 1'b1 : '0;
    end
  end

endmodule

// File: hdl/binomial_coefficient.sv
// Binomial coefficient C(n,m): top level joining controller and datapath.
// Depends on bc_pkg, bc_controller, bc_datapath.
//
// Usage: an item (n_items, m_taken) is taken at a clock edge where start is
// high and busy is low. Exactly one result comes back: combinations and
// status are shown for one cycle with done high. status is OK, OVF
// (combinations all ones, true value exceeds 64 bits) or DOM (m > n,
// combinations zero). m is replaced by n-m when 2m > n.
// Without any step (m = 0, m = n, or a domain error) the item goes from load
// through the check state to finish; otherwise each of the k = min(m, n-m)
// steps runs one multiply, the bit-serial exact divider and one update. An
// overflow ends the item after the step that overflows. At most 33 steps fit
// in 64 bits (n = 67, m = 33). One item is in work at a time; busy drops in
// the cycle done is shown, so the next item may be started then. The
// receiver cannot stall: results must be taken in the done cycle. Synchronous
// reset rst returns the controller to idle and clears done.
module binomial_coefficient (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [bc_pkg::N_W-1:0]    n_items,
  input  logic [bc_pkg::N_W-1:0]    m_taken,
  output logic                      busy,
  output logic                      done,
  output logic [bc_pkg::VAL_W-1:0]  combinations,
  output logic [bc_pkg::STAT_W-1:0] status
);

  bc_pkg::bc_cmd_t  cmd;
  bc_pkg::bc_stat_t stat;

  bc_controller u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  bc_datapath u_dp (
    .clk          (clk),
    .n_items      (n_items),
    .m_taken      (m_taken),
    .cmd          (cmd),
    .stat         (stat),
    .combinations (combinations),
    .status       (status)
  );

endmodule

// File: hdl/bc_checker.sv
// Port-level checks for binomial_coefficient, attached with bind.
// Depends on bc_pkg.
module bc_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      start,
  input logic [bc_pkg::N_W-1:0]    n_items,
  input logic [bc_pkg::N_W-1:0]    m_taken,
  input logic                      busy,
  input logic                      done,
  input logic [bc_pkg::VAL_W-1:0]  combinations,
  input logic [bc_pkg::STAT_W-1:0] status
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && !$past(done))
    else $error("done while busy or repeated");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == bc_pkg::STATUS_OK) || (status == bc_pkg::STATUS_OVF) ||
             (status == bc_pkg::STATUS_DOM))
    else $error("undefined status code");

  a_dom_zero: assert property (@(posedge clk) disable iff (rst)
    done && (status == bc_pkg::STATUS_DOM) |-> (combinations == '0))
    else $error("domain result not zero");

  a_ovf_ones: assert property (@(posedge clk) disable iff (rst)
    done && (status == bc_pkg::STATUS_OVF) |-> (combinations == '1))
    else $error("overflow result not saturated");

endmodule

bind binomial_coefficient bc_checker u_bc_checker (.*);

// File: tb/sv/tb.sv
// Self-checking testbench for binomial_coefficient: drives (n, m) requests
// through the start/busy handshake and checks each done strobe against an
// internal predictor of C(n,m). Depends on bc_pkg and binomial_coefficient.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 25000;
  localparam int IDLE_PCT       = 22;

  typedef struct {
    logic [bc_pkg::VAL_W-1:0] value;
    bc_pkg::status_t          code;
  } answer_t;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      start;
  logic [bc_pkg::N_W-1:0]    n_items;
  logic [bc_pkg::N_W-1:0]    m_taken;
  logic                      busy;
  logic                      done;
  logic [bc_pkg::VAL_W-1:0]  combinations;
  logic [bc_pkg::STAT_W-1:0] status;

  answer_t pending_answers[$];
  bit      gaps_on = 1'b1;
  int      err_count = 0;
  int      n_requests = 0;
  int      n_answers = 0;
  int      n_ok = 0;
  int      n_saturated = 0;
  int      n_domain = 0;
  int      idle_cycles = 0;

  binomial_coefficient uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .n_items      (n_items),
    .m_taken      (m_taken),
    .busy         (busy),
    .done         (done),
    .combinations (combinations),
    .status       (status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // multiplicative C(n,m) with exact division on a wide product
  function automatic answer_t calc_binomial(input logic [bc_pkg::N_W-1:0] n,
                                            input logic [bc_pkg::N_W-1:0] m);
    answer_t                a;
    int                     k;
    logic [bc_pkg::N_W-1:0] fall;
    logic [127:0]           prod;
    logic [127:0]           quot;
    a.value = '0;
    a.code  = bc_pkg::STATUS_OK;
    if (m > n || int'(n) > bc_pkg::N_MAX) begin
      a.code = bc_pkg::STATUS_DOM;
      return a;
    end
    k = (2 * int'(m) > int'(n)) ? int'(n) - int'(m) : int'(m);
    a.value = bc_pkg::VAL_W'(1);
    fall = n;
    for (int i = 1; i <= k; i++) begin
      prod = 128'(a.value) * 128'(fall);
      quot = prod / 128'(i);
      if (quot[127:bc_pkg::VAL_W] != '0) begin
        a.value = '1;
        a.code  = bc_pkg::STATUS_OVF;
        break;
      end
      a.value = quot[bc_pkg::VAL_W-1:0];
      fall = fall - 1'b1;
    end
    return a;
  endfunction

  task automatic issue_request(input logic [bc_pkg::N_W-1:0] n,
                               input logic [bc_pkg::N_W-1:0] m);
    answer_t a;
    int      gap;
    a = calc_binomial(n, m);
    if (gaps_on && $urandom_range(99) < IDLE_PCT) begin
      gap = ($urandom_range(3) == 0) ? $urandom_range(1, 300) : $urandom_range(1, 4);
      start <= 1'b0;
      repeat (gap) begin
        n_items <= bc_pkg::N_W'($urandom);
        m_taken <= bc_pkg::N_W'($urandom);
        @(posedge clk);
      end
    end
    start   <= 1'b1;
    n_items <= n;
    m_taken <= m;
    do @(posedge clk); while (busy);
    pending_answers.push_back(a);
    n_requests++;
    case (a.code)
      bc_pkg::STATUS_OK:  n_ok++;
      bc_pkg::STATUS_OVF: n_saturated++;
      default:            n_domain++;
    endcase
  endtask

  // mostly few steps: m or n-m near zero, some out of domain
  task automatic short_request();
    int n;
    int k;
    n = $urandom_range(0, 127);
    if (n < 127 && $urandom_range(99) < 15) begin
      issue_request(bc_pkg::N_W'(n), bc_pkg::N_W'($urandom_range(n + 1, 127)));
    end else begin
      k = $urandom_range(0, 6);
      if (k > n) k = n;
      issue_request(bc_pkg::N_W'(n), bc_pkg::N_W'($urandom_range(1) ? k : n - k));
    end
  endtask

  task automatic test_edges();
    issue_request(0, 0);
    issue_request(127, 0);
    issue_request(127, 127);
    issue_request(0, 1);
    issue_request(0, 127);
    issue_request(5, 6);
    issue_request(126, 127);
    issue_request(1, 0);
    issue_request(1, 1);
    issue_request(2, 1);
    issue_request(10, 5);
    issue_request(127, 1);
    issue_request(127, 126);
    issue_request(100, 2);
    issue_request(127, 10);
    issue_request(64, 32);
    issue_request(66, 33);
    issue_request(67, 33);
    issue_request(67, 34);
    issue_request(68, 34);
    issue_request(85, 42);
    issue_request(127, 63);
    issue_request(127, 64);
  endtask

  task automatic test_short_runs();
    repeat (60) short_request();
  endtask

  task automatic test_full_range();
    int n;
    repeat (35) begin
      n = $urandom_range(34, 127);
      if ($urandom_range(7) == 0)
        issue_request(bc_pkg::N_W'($urandom), bc_pkg::N_W'($urandom));
      else
        issue_request(bc_pkg::N_W'(n), bc_pkg::N_W'($urandom_range(0, n)));
    end
  endtask

  task automatic test_back_to_back();
    gaps_on = 1'b0;
    repeat (20) short_request();
    gaps_on = 1'b1;
  endtask

  always @(posedge clk) begin
    answer_t e;
    if (!rst && done) begin
      n_answers++;
      if (pending_answers.size() == 0) begin
        $error("result with nothing expected: combinations=%0h status=%0d",
               combinations, status);
        err_count++;
      end else begin
        e = pending_answers.pop_front();
        if (combinations !== e.value) begin
          $error("combinations: expected %0h, got %0h", e.value, combinations);
          err_count++;
        end
        if (status !== e.code) begin
          $error("status: expected %0d, got %0d", e.code, status);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || done || (start && !busy))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[binomial_coefficient] ERROR");
      $finish;
    end
  end

  initial begin
    rst     <= 1'b1;
    start   <= 1'b0;
    n_items <= '0;
    m_taken <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_edges();
    test_short_runs();
    test_full_range();
    test_back_to_back();

    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("%0d requests, %0d results: %0d exact, %0d saturated, %0d out of domain",
             n_requests, n_answers, n_ok, n_saturated, n_domain);
    $display("%0d mismatches or unexpected results", err_count);
    if (err_count == 0)
      $display("[binomial_coefficient] OK");
    else
      $display("[binomial_coefficient] ERROR");
    $finish;
  end

endmodule
